### design/pngcrc_pkg.sv
// Shared types, constants and the CRC-32 table function for the PNG chunk framer.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package pngcrc_pkg;

   // Width of the payload length counter.
   localparam int LENGTH_BITS = 31;

   localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
   localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;

   // Request codes carried in req_type.
   localparam logic REQ_BEGIN = 1'b0;
   localparam logic REQ_BYTE  = 1'b1;

   // Back end step codes: length bytes, type bytes, one payload byte, CRC bytes.
   typedef logic [3:0] step_type;
   localparam step_type STEP_LEN0  = 4'd0;
   localparam step_type STEP_LEN3  = 4'd3;
   localparam step_type STEP_TYPE0 = 4'd4;
   localparam step_type STEP_TYPE3 = 4'd7;
   localparam step_type STEP_DATA  = 4'd8;
   localparam step_type STEP_CRC0  = 4'd9;
   localparam step_type STEP_CRC3  = 4'd12;

   // Input word.
   typedef struct packed {
      logic        req_type;
      logic [31:0] chunk_type;
      logic [30:0] payload_length;
      logic [7:0]  data_byte;
   } req_word_type;

   // Result word.
   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_run;
      logic       chunk_done;
      logic       protocol_error;
   } rsp_word_type;

   // Command kinds decided by the front end.
   typedef enum logic [1:0] {
      CMD_BEGIN,
      CMD_DATA,
      CMD_DROP
   } cmd_kind_type;

   // One classified command as it travels through the queue.
   typedef struct packed {
      cmd_kind_type           kind;
      logic                   err;
      logic                   close;
      logic [31:0]            chunk_type;
      logic [LENGTH_BITS-1:0] length;
      logic [7:0]             data;
   } cmd_type;

   // One entry of the reflected CRC-32 byte table.
   function automatic logic [31:0] crc_table_entry(input logic [7:0] idx);
      logic [31:0] c;
      c = {24'd0, idx};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
      end
      return c;
   endfunction

   // Advance a running CRC by one byte.
   function automatic logic [31:0] crc_update(input logic [31:0] crc, input logic [7:0] b);
      return crc_table_entry(crc[7:0] ^ b) ^ (crc >> 8);
   endfunction

endpackage

`default_nettype wire

### design/pngcrc_front.sv
// Front end of the PNG chunk framer: accepts request words, tracks the open chunk
// and its remaining byte count, and pushes classified commands. Uses pngcrc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pngcrc_front (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire pngcrc_pkg::req_word_type req_word,
   output logic                         push_valid,
   input  wire logic                    push_ready,
   output pngcrc_pkg::cmd_type          push_cmd
);
   import pngcrc_pkg::*;

   logic                   open_ff, open_in;
   logic [LENGTH_BITS-1:0] left_ff, left_in;
   logic [LENGTH_BITS-1:0] len_masked;
   logic                   accept;

   assign req_ready  = push_ready;
   assign push_valid = req_valid;
   assign accept     = req_valid && push_ready;
   assign len_masked = req_word.payload_length[LENGTH_BITS-1:0];

   // Classify the word and work out the chunk state it leaves behind.
   always_comb begin
      open_in             = open_ff;
      left_in             = left_ff;
      push_cmd.kind       = CMD_DROP;
      push_cmd.err        = 1'b1;
      push_cmd.close      = 1'b0;
      push_cmd.chunk_type = req_word.chunk_type;
      push_cmd.length     = len_masked;
      push_cmd.data       = req_word.data_byte;
      if (req_word.req_type == REQ_BEGIN) begin
         push_cmd.kind  = CMD_BEGIN;
         push_cmd.err   = open_ff;
         push_cmd.close = (len_masked == '0);
         open_in        = (len_masked != '0);
         left_in        = len_masked;
      end else if (open_ff) begin
         push_cmd.kind  = CMD_DATA;
         push_cmd.err   = 1'b0;
         push_cmd.close = (left_ff == LENGTH_BITS'(1));
         open_in        = (left_ff != LENGTH_BITS'(1));
         left_in        = left_ff - LENGTH_BITS'(1);
      end
   end

   // Chunk state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= 1'b0;
         left_ff <= '0;
      end else if (accept) begin
         open_ff <= open_in;
         left_ff <= left_in;
      end
   end

endmodule

`default_nettype wire

### design/pngcrc_queue.sv
// Two-entry command queue between the front and back ends of the chunk framer.
// Uses pngcrc_pkg for the command type.
`timescale 1ns / 1ps
`default_nettype none

module pngcrc_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push_valid,
   output logic                    push_ready,
   input  wire pngcrc_pkg::cmd_type push_cmd,
   output logic                    pop_valid,
   input  wire logic               pop,
   output pngcrc_pkg::cmd_type     pop_cmd
);
   import pngcrc_pkg::*;

   cmd_type     entry_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        do_push, do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_cmd    = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

### design/pngcrc_back.sv
// Chunk framer back end: serializes each command into output bytes, one per cycle
// unless stalled; runs the table CRC, holds the result register. Uses pngcrc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pngcrc_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               cmd_valid,
   output logic                    cmd_pop,
   input  wire pngcrc_pkg::cmd_type cmd_head,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output pngcrc_pkg::rsp_word_type rsp_word
);
   import pngcrc_pkg::*;

   cmd_type      cmd_ff;
   step_type     step_ff, step_in;
   logic         busy_ff, busy_in;
   logic [31:0]  crc_ff, crc_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_word_ff, rsp_word_in;

   logic         out_adv, emit, finish;
   step_type     end_step, start_step;
   logic [31:0]  len_word, crc_out;
   logic [7:0]   cur_byte;
   logic [1:0]   len_idx, type_idx, crc_idx;

   assign out_adv = !rsp_valid_ff || rsp_ready;
   assign emit    = busy_ff && out_adv;
   assign finish  = emit && (step_ff == end_step);
   assign cmd_pop = cmd_valid && (!busy_ff || finish);

   assign len_word = 32'(cmd_ff.length);
   assign crc_out  = crc_ff ^ CRC_ONES;
   assign len_idx  = 2'(STEP_LEN3 - step_ff);
   assign type_idx = 2'(STEP_TYPE3 - step_ff);
   assign crc_idx  = 2'(STEP_CRC3 - step_ff);

   // Where the current command ends and where the next one starts.
   always_comb begin
      if (cmd_ff.close) begin
         end_step = STEP_CRC3;
      end else if (cmd_ff.kind == CMD_BEGIN) begin
         end_step = STEP_TYPE3;
      end else begin
         end_step = STEP_DATA;
      end
      start_step = (cmd_head.kind == CMD_BEGIN) ? STEP_LEN0 : STEP_DATA;
   end

   // Byte for the current step.
   always_comb begin
      if (step_ff <= STEP_LEN3) begin
         cur_byte = len_word[len_idx*8 +: 8];
      end else if (step_ff <= STEP_TYPE3) begin
         cur_byte = cmd_ff.chunk_type[type_idx*8 +: 8];
      end else if (step_ff == STEP_DATA) begin
         cur_byte = (cmd_ff.kind == CMD_DROP) ? 8'd0 : cmd_ff.data;
      end else begin
         cur_byte = crc_out[crc_idx*8 +: 8];
      end
   end

   // Sequencer, CRC and output register next values.
   always_comb begin
      busy_in      = busy_ff;
      step_in      = step_ff;
      crc_in       = crc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_word_in  = rsp_word_ff;
      if (emit) begin
         rsp_valid_in               = 1'b1;
         rsp_word_in.out_byte       = cur_byte;
         rsp_word_in.last_of_run    = (step_ff == end_step);
         rsp_word_in.chunk_done     = (step_ff == STEP_CRC3);
         rsp_word_in.protocol_error = cmd_ff.err;
         if (step_ff == STEP_LEN0) begin
            crc_in = CRC_ONES;
         end else if (step_ff >= STEP_TYPE0 && step_ff <= STEP_TYPE3) begin
            crc_in = crc_update(crc_ff, cur_byte);
         end else if (step_ff == STEP_DATA && cmd_ff.kind == CMD_DATA) begin
            crc_in = crc_update(crc_ff, cur_byte);
         end
         step_in = (step_ff == STEP_TYPE3) ? STEP_CRC0 : step_ff + step_type'(1);
      end
      if (cmd_pop) begin
         busy_in = 1'b1;
         step_in = start_step;
      end else if (finish) begin
         busy_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         crc_ff       <= CRC_ONES;
         step_ff      <= STEP_LEN0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         crc_ff       <= crc_in;
         step_ff      <= step_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
      if (cmd_pop) begin
         cmd_ff <= cmd_head;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

`default_nettype wire

### design/png_chunk_crc32_framer_top.sv
// Top level of the PNG chunk framer: front end, command queue and back end.
// Depends on pngcrc_pkg, pngcrc_front, pngcrc_queue and pngcrc_back.
//
// Usage:
//   req_* carries one request word per handshake: a begin (chunk type and
//   payload length) or one payload byte. rsp_* carries one framed output byte
//   per word, with last_of_run, chunk_done and protocol_error flags.
//   A begin produces 8 words (length and type bytes), or 12 for an empty chunk.
//   A payload byte produces 1 word, or 5 when it closes the chunk with its CRC.
//   A byte with no open chunk produces one zero word flagged as an error.
//   When the block is idle, the first result word of a request passes through
//   the queue entry, the back end's command register and the output register.
//   The back end's byte serializer emits one word per cycle while the receiver
//   accepts them, so payload bytes stream at one per cycle. A two-entry queue
//   lets requests be taken while results wait.
//   Reset is synchronous and closes any open chunk; no words are pending after.
//   When the receiver stalls, the output register holds its word and the
//   queue fills; req_ready falls once both queue entries are taken.
`timescale 1ns / 1ps
`default_nettype none

module png_chunk_crc32_framer_top (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire pngcrc_pkg::req_word_type req_word,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output pngcrc_pkg::rsp_word_type     rsp_word
);
   import pngcrc_pkg::*;

   logic    push_valid, push_ready;
   cmd_type push_cmd;
   logic    q_valid, q_pop;
   cmd_type q_cmd;

   pngcrc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_word   (req_word),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd)
   );

   pngcrc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (q_valid),
      .pop        (q_pop),
      .pop_cmd    (q_cmd)
   );

   pngcrc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (q_valid),
      .cmd_pop   (q_pop),
      .cmd_head  (q_cmd),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

`ifndef ASSERT_OFF
   // The last CRC byte always ends the run of its request.
   assert property (@(posedge clock) rsp_valid && rsp_word.chunk_done |-> rsp_word.last_of_run)
      else $error("chunk_done without last_of_run");

   // Nothing is presented in the first cycle after reset is released.
   assert property (@(posedge clock) !reset && $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // The back end never takes a command from an empty queue.
   assert property (@(posedge clock) disable iff (reset) q_pop |-> q_valid)
      else $error("pop from empty command queue");
`endif

endmodule

`default_nettype wire
